>>> rtl/vmpc_pkg.sv
// Shared types and constants for the valve motor position controller.
package vmpc_pkg;

    // Operation codes carried in the op field of an input beat
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_PULSE       = 3'd1;
    localparam logic [2:0] OP_MOVE        = 3'd2;
    localparam logic [2:0] OP_ADAPT_OPEN  = 3'd3;
    localparam logic [2:0] OP_ADAPT_CLOSE = 3'd4;

    // Configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] CFG_STALL_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_OPEN_RUNTIME  = 2'd1;
    localparam logic [1:0] CFG_CLOSE_RUNTIME = 2'd2;
    localparam logic [1:0] CFG_MIN_TRAVEL    = 2'd3;

    // Configuration reset values
    localparam logic [15:0] STALL_LIMIT_RST   = 16'd20;
    localparam logic [15:0] OPEN_RUNTIME_RST  = 16'd5000;
    localparam logic [15:0] CLOSE_RUNTIME_RST = 16'd5000;
    localparam logic [14:0] MIN_TRAVEL_RST    = 15'd100;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Motor drive direction
    typedef enum logic [1:0] {
        MOTOR_HALT    = 2'b00,
        MOTOR_OPENING = 2'b01,
        MOTOR_CLOSING = 2'b10
    } dir_t;

    // Run mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_MOVE   = 4'b0010,
        MODE_AOPEN  = 4'b0100,
        MODE_ACLOSE = 4'b1000
    } mode_t;

    // Completion status of a run
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_RUNTIME = 2'd1,
        STATUS_RANGE   = 2'd2
    } status_t;

endpackage

>>> rtl/valve_motor_position_controller_core.sv
// Valve motor position controller: input register, state update, result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, op, target_position   | in
//  result  | out_valid, out_stall, drive_open .. adapted| out
//  config  | psel, penable, pwrite, paddr, pwdata ...  | in/out
//
// One beat is taken per cycle while in_stall is low; a beat is held in the input
// register and its result in the result register before the result beat is taken.
// The position, counters and run mode are registered from the input register as each
// beat is processed, so a following beat always sees the state its predecessor left.
// Reset clears the controller state and valid flags and loads the configuration defaults.
// A stalled result holds the input register; in_stall rises only while both are full.
module valve_motor_position_controller_core
    import vmpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [15:0] target_position,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               drive_open,
    output logic               drive_close,
    output logic               driver_enabled,
    output logic               done_res,
    output logic [1:0]         status,
    output logic signed [15:0] position,
    output logic               adapted,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic [15:0] stall_limit_reg;
    logic [15:0] open_runtime_reg;
    logic [15:0] close_runtime_reg;
    logic [14:0] min_travel_reg;

    // Input register
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [15:0] target_reg;

    // Controller state
    logic [15:0] pos_reg,     pos_next;
    logic [15:0] range_reg,   range_next;
    logic [15:0] goal_reg,    goal_next;
    dir_t        dir_reg,     dir_next;
    logic        running_reg, running_next;
    logic        enabled_reg, enabled_next;
    logic [15:0] stall_reg,   stall_next;
    logic [15:0] run_reg,     run_next;
    mode_t       mode_reg,    mode_next;
    logic        done_next;
    status_t     status_next;

    // Result register
    logic        out_valid_reg;
    logic        drive_open_reg;
    logic        drive_close_reg;
    logic        enabled_out_reg;
    logic        done_reg;
    status_t     status_reg;
    logic [15:0] position_reg;
    logic        adapted_reg;

    logic        cfg_write;
    logic        in_accept;
    logic        out_free;
    logic        proc;
    logic [15:0] stall_inc;
    logic [15:0] range_neg;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_STALL_LIMIT:   prdata = {16'd0, stall_limit_reg};
            CFG_OPEN_RUNTIME:  prdata = {16'd0, open_runtime_reg};
            CFG_CLOSE_RUNTIME: prdata = {16'd0, close_runtime_reg};
            CFG_MIN_TRAVEL:    prdata = {17'd0, min_travel_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_limit_reg   <= STALL_LIMIT_RST;
            open_runtime_reg  <= OPEN_RUNTIME_RST;
            close_runtime_reg <= CLOSE_RUNTIME_RST;
            min_travel_reg    <= MIN_TRAVEL_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                CFG_STALL_LIMIT:   stall_limit_reg   <= pwdata[15:0];
                CFG_OPEN_RUNTIME:  open_runtime_reg  <= pwdata[15:0];
                CFG_CLOSE_RUNTIME: close_runtime_reg <= pwdata[15:0];
                CFG_MIN_TRAVEL:    min_travel_reg    <= pwdata[14:0];
                default:           ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_accept || (in_valid_reg && !proc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= op;
            target_reg <= target_position;
        end
    end

    // a close run only ends on a tick, which leaves the position as it was
    assign stall_inc = (stall_reg != CNT_MAX) ? stall_reg + 16'd1 : stall_reg;
    assign range_neg = ~pos_reg + 16'd1;

    // State update for one beat
    always_comb
    begin
        pos_next     = pos_reg;
        range_next   = range_reg;
        goal_next    = goal_reg;
        dir_next     = dir_reg;
        running_next = running_reg;
        enabled_next = enabled_reg;
        stall_next   = stall_reg;
        run_next     = run_reg;
        mode_next    = mode_reg;
        done_next    = 1'b0;
        status_next  = STATUS_OK;

        unique case (op_reg)
            OP_TICK:
            begin
                stall_next = stall_inc;
                if (stall_inc > stall_limit_reg)
                begin
                    dir_next     = MOTOR_HALT;
                    running_next = 1'b0;
                end
                if (running_next && run_reg != CNT_MAX)
                    run_next = run_reg + 16'd1;
                // goal reached or passed
                if (range_reg != 16'd0)
                begin
                    if (dir_next == MOTOR_OPENING && $signed(pos_reg) >= $signed(goal_reg))
                    begin
                        dir_next     = MOTOR_HALT;
                        running_next = 1'b0;
                    end
                    else if (dir_next == MOTOR_CLOSING && $signed(pos_reg) <= $signed(goal_reg))
                    begin
                        dir_next     = MOTOR_HALT;
                        running_next = 1'b0;
                    end
                end
                // runtime limits of the adaptation runs
                if ((mode_reg == MODE_AOPEN && run_next > open_runtime_reg) ||
                    (mode_reg == MODE_ACLOSE && run_next > close_runtime_reg))
                begin
                    dir_next     = MOTOR_HALT;
                    running_next = 1'b0;
                end
            end
            OP_PULSE:
            begin
                if (dir_reg == MOTOR_OPENING)
                    pos_next = pos_reg + 16'd1;
                else if (dir_reg == MOTOR_CLOSING)
                    pos_next = pos_reg - 16'd1;
                stall_next = 16'd0;
            end
            OP_MOVE:
            begin
                enabled_next = 1'b1;
                run_next     = 16'd0;
                stall_next   = 16'd0;
                if ($signed(target_reg) > $signed(pos_reg))
                begin
                    dir_next     = MOTOR_OPENING;
                    running_next = 1'b1;
                end
                else if ($signed(target_reg) < $signed(pos_reg))
                begin
                    dir_next     = MOTOR_CLOSING;
                    running_next = 1'b1;
                end
                goal_next = target_reg;
                mode_next = MODE_MOVE;
            end
            OP_ADAPT_OPEN:
            begin
                enabled_next = 1'b1;
                run_next     = 16'd0;
                stall_next   = 16'd0;
                dir_next     = MOTOR_OPENING;
                running_next = 1'b1;
                mode_next    = MODE_AOPEN;
            end
            OP_ADAPT_CLOSE:
            begin
                enabled_next = 1'b1;
                run_next     = 16'd0;
                stall_next   = 16'd0;
                dir_next     = MOTOR_CLOSING;
                running_next = 1'b1;
                mode_next    = MODE_ACLOSE;
            end
            default: ;
        endcase

        // Run finished: wrap up according to mode
        if (mode_next != MODE_IDLE && !running_next)
        begin
            done_next = 1'b1;
            if (mode_next == MODE_AOPEN)
            begin
                pos_next     = 16'd0;
                enabled_next = 1'b0;
                status_next  = (run_next <= open_runtime_reg) ? STATUS_OK : STATUS_RUNTIME;
            end
            else if (mode_next == MODE_ACLOSE)
            begin
                enabled_next = 1'b0;
                if (run_next <= close_runtime_reg)
                begin
                    range_next = range_neg;
                    pos_next   = 16'd0;
                    if ($signed(range_neg) < $signed({1'b0, min_travel_reg}))
                    begin
                        range_next  = 16'd0;
                        status_next = STATUS_RANGE;
                    end
                end
                else
                begin
                    status_next = STATUS_RUNTIME;
                end
            end
            mode_next = MODE_IDLE;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 16'd0;
            range_reg   <= 16'd0;
            goal_reg    <= 16'd0;
            dir_reg     <= MOTOR_HALT;
            running_reg <= 1'b0;
            enabled_reg <= 1'b0;
            stall_reg   <= 16'd0;
            run_reg     <= 16'd0;
            mode_reg    <= MODE_IDLE;
        end
        else if (proc)
        begin
            pos_reg     <= pos_next;
            range_reg   <= range_next;
            goal_reg    <= goal_next;
            dir_reg     <= dir_next;
            running_reg <= running_next;
            enabled_reg <= enabled_next;
            stall_reg   <= stall_next;
            run_reg     <= run_next;
            mode_reg    <= mode_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= proc || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            drive_open_reg  <= (dir_next == MOTOR_OPENING);
            drive_close_reg <= (dir_next == MOTOR_CLOSING);
            enabled_out_reg <= enabled_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            position_reg    <= pos_next;
            adapted_reg     <= (range_next != 16'd0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_open     = drive_open_reg;
    assign drive_close    = drive_close_reg;
    assign driver_enabled = enabled_out_reg;
    assign done_res       = done_reg;
    assign status         = status_reg;
    assign position       = position_reg;
    assign adapted        = adapted_reg;

endmodule

>>> sim/vmpc_motor_checker.sv
// Checker for the valve motor controller: predicts each result beat and compares it.
module vmpc_motor_checker
    import vmpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [15:0] target_position,

    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               drive_open,
    input  logic               drive_close,
    input  logic               driver_enabled,
    input  logic               done_res,
    input  logic [1:0]         status,
    input  logic signed [15:0] position,
    input  logic               adapted,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,

    output int                 mismatches,
    output int                 in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        drv_open;
        logic        drv_close;
        logic        drv_en;
        logic        done;
        logic [1:0]  status;
        logic [15:0] pos;
        logic        adapted;
    } motor_result_t;

    // Shadow of the configuration registers
    logic [15:0] stall_lim;
    logic [15:0] open_lim;
    logic [15:0] close_lim;
    logic [14:0] min_trav;

    // Shadow of the motor state
    logic [15:0] pos_cnt;
    logic [15:0] range_cnt;
    logic [15:0] goal_pos;
    logic [15:0] stall_cnt;
    logic [15:0] run_cnt;
    dir_t        dir_q;
    mode_t       mode_q;
    logic        run_q;
    logic        en_q;

    motor_result_t motor_results_due[$];
    int            errors = 0;

    function automatic void halt_motor();
        dir_q = MOTOR_HALT;
        run_q = 1'b0;
    endfunction

    function automatic void arm_driver();
        en_q      = 1'b1;
        run_cnt   = '0;
        stall_cnt = '0;
    endfunction

    // Advance the shadow state by one input beat and return the result it produces
    function automatic motor_result_t step_motor(logic [2:0] opc, logic [15:0] tgt);
        motor_result_t r;
        logic          fin;
        logic [1:0]    st;
        fin = 1'b0;
        st  = STATUS_OK;
        case (opc)
            OP_TICK: begin
                if (stall_cnt != CNT_MAX)
                    stall_cnt = stall_cnt + 16'd1;
                if (stall_cnt > stall_lim)
                    halt_motor();
                if (run_q && run_cnt != CNT_MAX)
                    run_cnt = run_cnt + 16'd1;
                // goal check only once the travel range is known
                if (range_cnt != '0) begin
                    if (dir_q == MOTOR_OPENING && $signed(pos_cnt) >= $signed(goal_pos))
                        halt_motor();
                    else if (dir_q == MOTOR_CLOSING && $signed(pos_cnt) <= $signed(goal_pos))
                        halt_motor();
                end
                if (mode_q == MODE_AOPEN && run_cnt > open_lim)
                    halt_motor();
                if (mode_q == MODE_ACLOSE && run_cnt > close_lim)
                    halt_motor();
            end
            OP_PULSE: begin
                if (dir_q == MOTOR_OPENING)
                    pos_cnt = pos_cnt + 16'd1;
                else if (dir_q == MOTOR_CLOSING)
                    pos_cnt = pos_cnt - 16'd1;
                stall_cnt = '0;
            end
            OP_MOVE: begin
                arm_driver();
                if ($signed(tgt) > $signed(pos_cnt)) begin
                    dir_q = MOTOR_OPENING;
                    run_q = 1'b1;
                end
                else if ($signed(tgt) < $signed(pos_cnt)) begin
                    dir_q = MOTOR_CLOSING;
                    run_q = 1'b1;
                end
                goal_pos = tgt;
                mode_q   = MODE_MOVE;
            end
            OP_ADAPT_OPEN: begin
                arm_driver();
                dir_q  = MOTOR_OPENING;
                run_q  = 1'b1;
                mode_q = MODE_AOPEN;
            end
            OP_ADAPT_CLOSE: begin
                arm_driver();
                dir_q  = MOTOR_CLOSING;
                run_q  = 1'b1;
                mode_q = MODE_ACLOSE;
            end
            default: ;
        endcase

        // run end: adaptation runs drop driver; open, in-time close zero position
        if (mode_q != MODE_IDLE && !run_q) begin
            fin = 1'b1;
            if (mode_q == MODE_AOPEN) begin
                pos_cnt = '0;
                en_q    = 1'b0;
                st      = (run_cnt <= open_lim) ? STATUS_OK : STATUS_RUNTIME;
            end
            else if (mode_q == MODE_ACLOSE) begin
                en_q = 1'b0;
                if (run_cnt <= close_lim) begin
                    range_cnt = -pos_cnt;
                    pos_cnt   = '0;
                    if ($signed(range_cnt) < $signed({1'b0, min_trav})) begin
                        range_cnt = '0;
                        st        = STATUS_RANGE;
                    end
                end
                else begin
                    st = STATUS_RUNTIME;
                end
            end
            mode_q = MODE_IDLE;
        end

        r.drv_open  = (dir_q == MOTOR_OPENING);
        r.drv_close = (dir_q == MOTOR_CLOSING);
        r.drv_en    = en_q;
        r.done      = fin;
        r.status    = st;
        r.pos       = pos_cnt;
        r.adapted   = (range_cnt != '0);
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Watch config writes, result beats and input beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        motor_result_t want;
        if (!rst_n)
        begin
            stall_lim = STALL_LIMIT_RST;
            open_lim  = OPEN_RUNTIME_RST;
            close_lim = CLOSE_RUNTIME_RST;
            min_trav  = MIN_TRAVEL_RST;
            pos_cnt   = '0;
            range_cnt = '0;
            goal_pos  = '0;
            stall_cnt = '0;
            run_cnt   = '0;
            dir_q     = MOTOR_HALT;
            mode_q    = MODE_IDLE;
            run_q     = 1'b0;
            en_q      = 1'b0;
            motor_results_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    CFG_STALL_LIMIT:   stall_lim = pwdata[15:0];
                    CFG_OPEN_RUNTIME:  open_lim  = pwdata[15:0];
                    CFG_CLOSE_RUNTIME: close_lim = pwdata[15:0];
                    CFG_MIN_TRAVEL:    min_trav  = pwdata[14:0];
                    default: ;
                endcase
            end
            // result beat against oldest prediction
            if (out_valid && !out_stall)
            begin
                if (motor_results_due.size() == 0)
                    flag_mismatch("result beat with no prediction waiting");
                else
                begin
                    want = motor_results_due.pop_front();
                    compare_field("drive_open", 16'(drive_open), 16'(want.drv_open));
                    compare_field("drive_close", 16'(drive_close), 16'(want.drv_close));
                    compare_field("driver_enabled", 16'(driver_enabled), 16'(want.drv_en));
                    compare_field("done_res", 16'(done_res), 16'(want.done));
                    compare_field("status", 16'(status), 16'(want.status));
                    compare_field("position", position, want.pos);
                    compare_field("adapted", 16'(adapted), 16'(want.adapted));
                end
            end
            if (in_valid && !in_stall)
                motor_results_due.push_back(step_motor(op, target_position));
        end
        in_flight  <= motor_results_due.size();
        mismatches <= errors;
    end

endmodule

>>> sim/valve_motor_position_controller_core_tb.sv
// Testbench top for the valve motor controller: stimulus, config writes and verdict.
module valve_motor_position_controller_core_tb
    import vmpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         op;
    logic signed [15:0] target_position;
    logic               out_valid;
    logic               out_stall;
    logic               drive_open;
    logic               drive_close;
    logic               driver_enabled;
    logic               done_res;
    logic [1:0]         status;
    logic signed [15:0] position;
    logic               adapted;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int mismatches;
    int in_flight;

    // stimulus shaping, shared with the receiver process
    bit tx_quiet;
    bit rx_quiet;
    bit rx_hold;
    int beats_sent  = 0;
    int cfg_stall   = 20;
    int idle_cycles = 0;

    valve_motor_position_controller_core u_top (.*);

    vmpc_motor_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [15:0] pick_limit();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(1, 4));
        return 16'($urandom_range(20, 200));
    endfunction

    // Offer one input beat and hold it until accepted
    task automatic send_beat(logic [2:0] opc, logic [15:0] tgt);
        int gap;
        in_valid        <= 1'b1;
        op              <= opc;
        target_position <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        if (!tx_quiet && $urandom_range(0, 2) == 0)
        begin
            gap = idle_len();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // APB write: setup, access, then back to idle
    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_cfg(logic [15:0] sl, logic [15:0] ol, logic [15:0] cl,
                             logic [14:0] mt);
        apb_write(CFG_STALL_LIMIT, {16'd0, sl});
        apb_write(CFG_OPEN_RUNTIME, {16'd0, ol});
        apb_write(CFG_CLOSE_RUNTIME, {16'd0, cl});
        apb_write(CFG_MIN_TRAVEL, {17'd0, mt});
        cfg_stall = int'(sl);
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic motor_activity(int n, int tick_odds);
        repeat (n)
            send_beat(($urandom_range(0, 99) < tick_odds) ? OP_TICK : OP_PULSE, rnd16());
    endtask

    // Enough ticks to trip a stall limit below 12, else 1 to 5; at times none
    task automatic stall_out();
        int n;
        if ($urandom_range(0, 9) != 0)
        begin
            n = (cfg_stall < 12) ? cfg_stall + 1 : $urandom_range(1, 5);
            repeat (n) send_beat(OP_TICK, rnd16());
        end
    endtask

    task automatic run_scenario();
        int                 kind;
        int                 n;
        logic [2:0]         any_op;
        logic signed [15:0] t;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            // noise: any op code, any target
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                any_op = 3'($urandom_range(0, 7));
                send_beat(any_op, rnd16());
            end
        end
        else if (kind < 5)
        begin
            // move, mostly to a nearby target
            if ($urandom_range(0, 9) == 0)
                t = rnd16();
            else
            begin
                t = 16'($urandom_range(0, 80));
                t = t - 16'sd40;
            end
            send_beat(OP_MOVE, t);
            motor_activity($urandom_range(2, 20), 40);
        end
        else if (kind < 7)
        begin
            send_beat(OP_ADAPT_OPEN, rnd16());
            motor_activity($urandom_range(0, 10), 40);
            stall_out();
        end
        else
        begin
            send_beat(OP_ADAPT_CLOSE, rnd16());
            motor_activity($urandom_range(0, 50), 12);
            stall_out();
        end
    endtask

    // Result side: random stalls, quiet stretches and one long hold
    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else if (rx_quiet || $urandom_range(0, 3) != 0)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** valve_motor_position_controller_core: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int quota;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = OP_TICK;
        target_position = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tx_quiet        = 1'b1;
        rx_quiet        = 1'b1;
        rx_hold         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unused codes, move at target, run replaced, runtime error,
        // adaptation, goal stop
        write_cfg(16'd1, 16'd1, 16'hFFFF, 15'd2);
        send_beat(3'd5, 16'sh7FFF);
        send_beat(3'd6, 16'sh8000);
        send_beat(3'd7, 16'sh0000);
        send_beat(OP_PULSE, 16'sh0000);
        send_beat(OP_MOVE, 16'sh0000);
        send_beat(OP_MOVE, 16'sh7FFF);
        send_beat(OP_PULSE, 16'sh0000);
        send_beat(OP_MOVE, 16'sh0001);
        send_beat(OP_ADAPT_OPEN, 16'sh0000);
        send_beat(OP_TICK, 16'sh0000);
        send_beat(OP_PULSE, 16'sh0000);
        send_beat(OP_TICK, 16'sh0000);
        send_beat(OP_ADAPT_CLOSE, 16'sh0000);
        repeat (3) send_beat(OP_PULSE, 16'sh0000);
        repeat (2) send_beat(OP_TICK, 16'sh0000);
        send_beat(OP_MOVE, 16'sh8000);
        send_beat(OP_TICK, 16'sh0000);
        send_beat(OP_MOVE, 16'sh0002);
        repeat (2) send_beat(OP_PULSE, 16'sh0000);
        send_beat(OP_TICK, 16'sh0000);
        send_beat(OP_MOVE, 16'sh0000);

        // Random phases, each with its own register setting
        for (int p = 0; p < 8; p++)
        begin
            drain();
            case (p)
                0: write_cfg(16'd1, 16'd1, 16'd1, 15'd0);
                1: write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
                default: write_cfg(16'($urandom_range(1, 8)), pick_limit(), pick_limit(),
                                   15'($urandom_range(0, 30)));
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (p == 2)
            begin
                // receiver holds off while the sender keeps offering
                tx_quiet = 1'b1;
                rx_hold  = 1'b1;
                quota    = beats_sent + 40;
                while (beats_sent < quota)
                    run_scenario();
                tx_quiet = 1'b0;
            end
            quota = beats_sent + 225;
            while (beats_sent < quota)
                run_scenario();
        end

        drain();

        if (mismatches == 0)
            $display("** valve_motor_position_controller_core: PASSED **");
        else
            $display("** valve_motor_position_controller_core: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/vmpc_pkg.sv
rtl/valve_motor_position_controller_core.sv
sim/vmpc_motor_checker.sv
sim/valve_motor_position_controller_core_tb.sv
